[rtl/core/text_console_engine_assert.svh]
// Assertion macros shared by the console engine RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH

// Clocked check, disabled while reset is high
`define TCE_ASSERT(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds across reset
`define TCE_ASSERT_NR(name, clk_s, prop, msg) \
  name: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[rtl/core/tce_pkg.sv]
// Shared types and constants for the text console engine.
// No dependencies; used by the controller, datapath and top level of the block.
package tce_pkg;

  // Default geometry
  localparam int CONSOLES_DEF  = 4;
  localparam int COLS_DEF      = 80;
  localparam int ROWS_DEF      = 25;
  localparam int MEM_CELLS_DEF = 16384;

  // Width of reported cell addresses
  localparam int OUT_AW = 14;

  localparam logic [7:0]  COLOR_RST    = 8'h07;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0a;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_BLANK     = 8'h20;
  localparam logic [7:0]  CH_NULL      = 8'h00;
  localparam logic [31:0] DIR_UP       = 32'd0;
  localparam logic [31:0] DIR_DOWN     = 32'd1;

  typedef enum logic [2:0] {
    ACT_PUT     = 3'd0,
    ACT_COLOR   = 3'd1,
    ACT_SELECT  = 3'd2,
    ACT_SCROLL  = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_GOTO    = 3'd5,
    ACT_READ    = 3'd6,
    ACT_INVALID = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FOLLOW,
    S_CLEAR,
    S_DONE
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic init_step;
    logic load;
    logic exec;
    logic follow_step;
    logic clr_step;
    logic clr_finish;
    logic out_load;
  } tce_ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    action_t action;
    logic    console_ok;
    logic    follow_more;
    logic    mem_last;
    logic    region_last;
  } tce_sts_t;

endpackage

[rtl/core/tce_in_if.sv]
// Input item channel of the text console engine.
// No dependencies.
interface tce_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  console_index;
  logic [7:0]  char_code;
  logic [31:0] argument;

  modport source(output valid, action, console_index, char_code, argument, input ready);
  modport sink(input valid, action, console_index, char_code, argument, output ready);
endinterface

[rtl/core/tce_out_if.sv]
// Result item channel of the text console engine.
// No dependencies.
interface tce_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        display_update;
  logic [13:0] cursor_position;
  logic [13:0] display_start;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  modport source(output valid, status, display_update, cursor_position, display_start,
                 cell_char, cell_attr, input ready);
  modport sink(input valid, status, display_update, cursor_position, display_start,
               cell_char, cell_attr, output ready);
endinterface

[rtl/core/tce_ctrl.sv]
// Sequencing state machine of the text console engine.
// Depends on tce_pkg and text_console_engine_assert.svh.
`include "text_console_engine_assert.svh"

module tce_ctrl import tce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tce_sts_t sts,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output tce_ctl_t ctl
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sts.mem_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.console_ok && sts.action == ACT_PUT) begin
          state_next = S_FOLLOW;
        end else if (sts.console_ok && sts.action == ACT_CLEAR) begin
          state_next = S_CLEAR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FOLLOW: begin
        if (!sts.follow_more) state_next = S_DONE;
      end
      S_CLEAR: begin
        if (sts.region_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_ready       = (state == S_IDLE);
    ctl.init_step   = (state == S_INIT);
    ctl.load        = (state == S_IDLE) && cmd_valid;
    ctl.exec        = (state == S_EXEC);
    ctl.follow_step = (state == S_FOLLOW) && sts.follow_more;
    ctl.clr_step    = (state == S_CLEAR);
    ctl.clr_finish  = (state == S_CLEAR) && sts.region_last;
    ctl.out_load    = (state == S_DONE) && out_free;
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `TCE_ASSERT(a_load_exec, clk, rst, ctl.load |=> state == S_EXEC, "accepted item not executed")
  `TCE_ASSERT(a_out_free, clk, rst, ctl.out_load |-> (!rsp_valid || rsp_ready), "result overwritten")
  `TCE_ASSERT(a_clear_run, clk, rst, (state == S_CLEAR && !sts.region_last) |=> state == S_CLEAR, "clear cut short")
  `TCE_ASSERT_NR(a_rst_init, clk, $past(rst) |-> state == S_INIT, "no memory sweep after reset")

endmodule

[rtl/core/tce_datapath.sv]
// Datapath of the text console engine: text memory, per-console tables, result register.
// Depends on tce_pkg.
module tce_datapath import tce_pkg::*; #(
  parameter int CONSOLES    = CONSOLES_DEF,
  parameter int SCREEN_COLS = COLS_DEF,
  parameter int SCREEN_ROWS = ROWS_DEF,
  parameter int MEM_CELLS   = MEM_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  tce_ctl_t    ctl,
  output tce_sts_t    sts,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic [2:0]  in_action,
  input  logic [1:0]  in_console_index,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_argument,
  output logic        out_status,
  output logic        out_display_update,
  output logic [13:0] out_cursor_position,
  output logic [13:0] out_display_start,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr
);

  localparam int AW           = $clog2(MEM_CELLS);
  localparam int CIW          = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int REGION_CELLS = ((MEM_CELLS / CONSOLES) / SCREEN_COLS) * SCREEN_COLS;
  localparam int REGION_ROWS  = REGION_CELLS / SCREEN_COLS;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int SCW          = $clog2(SCREEN_CELLS + 1);
  localparam int WW           = ((AW > SCW) ? AW : SCW) + 1;
  localparam int COLW         = $clog2(SCREEN_COLS);
  localparam int YW           = $clog2(REGION_ROWS + 1);
  localparam int EW           = AW + OUT_AW;

  // Text memory
  logic [15:0]   mem [MEM_CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   rd_data;

  // Per-console tables
  logic [AW-1:0]   cursor_tab [CONSOLES];
  logic [AW-1:0]   view_tab   [CONSOLES];
  logic [COLW-1:0] col_tab    [CONSOLES];
  logic [7:0]      color_tab  [CONSOLES];
  logic [CIW-1:0]  shown;
  logic [7:0]      default_color;

  // Latched item
  action_t        act;
  logic           c_ok;
  logic [CIW-1:0] tc;
  logic [7:0]     ch;
  logic [31:0]    arg;
  logic [WW-1:0]  base;
  logic [AW-1:0]  cnt;

  logic [2:0]      c_ext;
  logic [WW-1:0]   cur_w, view_w, reg_end, view_scr;
  logic [COLW-1:0] col;
  logic [7:0]      color;
  logic            is_nl, is_bs, nl_ok, bs_ok, pc_ok, sel_ok, rd_ok, touched, upd;
  logic [WW-1:0]   put_cur;
  logic [COLW-1:0] put_col;
  logic [WW-1:0]   scroll_view;
  logic [15:0]     gx, gy;
  logic [COLW-1:0] xs;
  logic [YW-1:0]   ys;
  logic [WW-1:0]   goto_cur;
  logic [EW-1:0]   cur_e, view_e;

  assign c_ext = {1'b0, in_console_index};

  // Item capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act  <= action_t'(in_action);
      c_ok <= {2'b00, in_console_index} < 4'(CONSOLES);
      tc   <= (action_t'(in_action) == ACT_SELECT) ? in_argument[CIW-1:0] : c_ext[CIW-1:0];
      ch   <= in_char_code;
      arg  <= in_argument;
      base <= WW'(((action_t'(in_action) == ACT_SELECT) ? in_argument[CIW-1:0]
                                                         : c_ext[CIW-1:0]) * REGION_CELLS);
    end
  end

  // Current console view
  always_comb begin
    cur_w    = WW'(cursor_tab[tc]);
    view_w   = WW'(view_tab[tc]);
    col      = col_tab[tc];
    color    = color_tab[tc];
    reg_end  = base + WW'(REGION_CELLS);
    view_scr = view_w + WW'(SCREEN_CELLS);
    sel_ok   = arg < 32'(CONSOLES);
    rd_ok    = arg < 32'(MEM_CELLS);
  end

  // Put char
  always_comb begin
    is_nl   = (ch == CH_NEWLINE);
    is_bs   = (ch == CH_BACKSPACE);
    nl_ok   = cur_w < reg_end - WW'(SCREEN_COLS);
    bs_ok   = cur_w > base;
    pc_ok   = cur_w < reg_end - WW'(1);
    put_cur = cur_w;
    put_col = col;
    if (is_nl) begin
      if (nl_ok) begin
        put_cur = cur_w - WW'(col) + WW'(SCREEN_COLS);
        put_col = '0;
      end
    end else if (is_bs) begin
      if (bs_ok) begin
        put_cur = cur_w - WW'(1);
        put_col = (col == '0) ? COLW'(SCREEN_COLS - 1) : col - COLW'(1);
      end
    end else if (pc_ok) begin
      put_cur = cur_w + WW'(1);
      put_col = (col == COLW'(SCREEN_COLS - 1)) ? '0 : col + COLW'(1);
    end
  end

  // Scroll and follow
  always_comb begin
    scroll_view = view_w;
    if (arg == DIR_UP) begin
      if (view_w > base) scroll_view = view_w - WW'(SCREEN_COLS);
    end else if (arg == DIR_DOWN) begin
      if (view_scr < reg_end) scroll_view = view_w + WW'(SCREEN_COLS);
    end
  end

  assign sts.follow_more = (cur_w >= view_scr) && (view_scr < reg_end);

  // Goto with saturation
  always_comb begin
    gx       = arg[31:16];
    gy       = arg[15:0];
    xs       = (gx > 16'(SCREEN_COLS - 1)) ? COLW'(SCREEN_COLS - 1) : gx[COLW-1:0];
    ys       = (32'(gy) > 32'(REGION_ROWS - 1)) ? YW'(REGION_ROWS - 1) : YW'(gy);
    goto_cur = base + WW'(WW'(ys) * WW'(SCREEN_COLS)) + WW'(xs);
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = 16'h0000;
    if (ctl.init_step) begin
      mem_we = 1'b1;
    end else if (ctl.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(base + WW'(cnt));
      mem_wdata = {default_color, CH_NULL};
    end else if (ctl.exec && c_ok && act == ACT_PUT && !is_nl) begin
      if (is_bs) begin
        mem_we    = bs_ok;
        mem_waddr = AW'(cur_w - WW'(1));
        mem_wdata = {color, CH_BLANK};
      end else begin
        mem_we    = pc_ok;
        mem_waddr = AW'(cur_w);
        mem_wdata = {color, ch};
      end
    end
    mem_re = ctl.exec && act == ACT_READ;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[arg[AW-1:0]];
  end

  // Sweep counter for reset fill and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.init_step) begin
      cnt <= sts.mem_last ? '0 : cnt + AW'(1);
    end else if (ctl.clr_step) begin
      cnt <= sts.region_last ? '0 : cnt + AW'(1);
    end
  end

  assign sts.mem_last    = (cnt == AW'(MEM_CELLS - 1));
  assign sts.region_last = (cnt == AW'(REGION_CELLS - 1));
  assign sts.action      = act;
  assign sts.console_ok  = c_ok;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= COLOR_RST;
    end else if (cfg_wr_en) begin
      default_color <= cfg_wr_data;
    end
  end

  // Console tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONSOLES; i++) begin
        cursor_tab[i] <= AW'(i * REGION_CELLS);
        view_tab[i]   <= AW'(i * REGION_CELLS);
        col_tab[i]    <= '0;
        color_tab[i]  <= COLOR_RST;
      end
      shown <= '0;
    end else begin
      if (ctl.exec && c_ok) begin
        case (act)
          ACT_PUT: begin
            cursor_tab[tc] <= AW'(put_cur);
            col_tab[tc]    <= put_col;
          end
          ACT_COLOR:  color_tab[tc] <= arg[7:0];
          ACT_SCROLL: view_tab[tc]  <= AW'(scroll_view);
          ACT_GOTO: begin
            cursor_tab[tc] <= AW'(goto_cur);
            view_tab[tc]   <= AW'(base);
            col_tab[tc]    <= xs;
          end
          default: ;
        endcase
      end
      if (ctl.exec && act == ACT_SELECT && sel_ok) shown <= arg[CIW-1:0];
      if (ctl.follow_step) view_tab[tc] <= AW'(view_w + WW'(SCREEN_COLS));
      if (ctl.clr_finish) begin
        cursor_tab[tc] <= AW'(base);
        view_tab[tc]   <= AW'(base);
        col_tab[tc]    <= '0;
      end
    end
  end

  // Result assembly
  always_comb begin
    touched = (act == ACT_SELECT && sel_ok) ||
              (c_ok && (act == ACT_PUT || act == ACT_SCROLL ||
                        act == ACT_CLEAR || act == ACT_GOTO));
    upd     = touched && (tc == shown);
    cur_e   = EW'(cursor_tab[tc]);
    view_e  = EW'(view_tab[tc]);
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status          <= (act == ACT_INVALID);
      out_display_update  <= upd;
      out_cursor_position <= upd ? cur_e[OUT_AW-1:0] : '0;
      out_display_start   <= upd ? view_e[OUT_AW-1:0] : '0;
      out_cell_char       <= (act == ACT_READ && rd_ok) ? rd_data[7:0] : 8'h00;
      out_cell_attr       <= (act == ACT_READ && rd_ok) ? rd_data[15:8] : 8'h00;
    end
  end

endmodule

[rtl/core/text_console_engine.sv]
// Top level of the multi-console text engine.
// Depends on tce_pkg, tce_in_if, tce_out_if, tce_ctrl and tce_datapath.

// After reset the block zeroes the text memory, one cell per cycle, and takes no item until
// every cell is written; configuration writes are taken at any time. Then each item passes
// through capture, execute and result; a put char adds a follow state that moves the view one
// line per step to follow the cursor, and a clear adds a sweep of REGION_CELLS writes because it
// writes the region through the single memory write port one cell a cycle. One item is in work at a time;
// a result may wait in the output register while the block sits ready for the next item.
module text_console_engine import tce_pkg::*; #(
  parameter int CONSOLES    = CONSOLES_DEF,
  parameter int SCREEN_COLS = COLS_DEF,
  parameter int SCREEN_ROWS = ROWS_DEF,
  parameter int MEM_CELLS   = MEM_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  tce_in_if.sink     cmd,
  tce_out_if.source  rsp
);

  tce_ctl_t ctl;
  tce_sts_t sts;

  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  tce_datapath #(
    .CONSOLES    (CONSOLES),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .MEM_CELLS   (MEM_CELLS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_action           (cmd.action),
    .in_console_index    (cmd.console_index),
    .in_char_code        (cmd.char_code),
    .in_argument         (cmd.argument),
    .out_status          (rsp.status),
    .out_display_update  (rsp.display_update),
    .out_cursor_position (rsp.cursor_position),
    .out_display_start   (rsp.display_start),
    .out_cell_char       (rsp.cell_char),
    .out_cell_attr       (rsp.cell_attr)
  );

endmodule

[test/tb_text_console_engine.sv]
// Self-checking testbench for text_console_engine: directed then random console actions.
// Depends on tce_pkg, tce_in_if, tce_out_if and the text_console_engine RTL.
// A behavioral console model predicts every result; a monitor compares them in order.
module tb_text_console_engine;
  import tce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS   = COLS_DEF;
  localparam int unsigned REGION = ((MEM_CELLS_DEF / CONSOLES_DEF) / COLS_DEF) * COLS_DEF;
  localparam int unsigned SCREEN = COLS_DEF * ROWS_DEF;
  localparam int unsigned LAST_ROW = REGION / COLS - 1;

  typedef struct packed {
    action_t     act;
    logic [1:0]  con;
    logic [7:0]  ch;
    logic [31:0] arg;
  } cmd_item_t;

  typedef struct packed {
    logic        status;
    logic        upd;
    logic [13:0] cur;
    logic [13:0] start;
    logic [7:0]  cch;
    logic [7:0]  cattr;
  } rsp_item_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  tce_in_if  cmd();
  tce_out_if rsp();

  text_console_engine i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .rsp(rsp)
  );

  // Console model state
  logic [15:0]  screen_mem [MEM_CELLS_DEF];
  int unsigned  cursor_at [CONSOLES_DEF];
  int unsigned  view_at [CONSOLES_DEF];
  logic [7:0]   color_of [CONSOLES_DEF];
  int unsigned  shown;
  logic [7:0]   blank_color;

  cmd_item_t pending_cmds [$];
  rsp_item_t console_expect_q [$];
  int        errors;
  bit        calm;

  // Scroll the view down until the cursor is on screen
  function automatic void follow_view(int unsigned c);
    while (cursor_at[c] >= view_at[c] + SCREEN && view_at[c] + SCREEN < c * REGION + REGION)
      view_at[c] += COLS;
  endfunction

  function automatic rsp_item_t predict_console(cmd_item_t it);
    rsp_item_t   r;
    int unsigned c;
    int unsigned base;
    int unsigned cur;
    int unsigned x;
    int unsigned y;
    int unsigned fc;
    bit          touched;
    r = '0;
    touched = 1'b0;
    c = 32'(it.con);
    fc = c;
    base = c * REGION;
    case (it.act)
      ACT_INVALID: r.status = 1'b1;
      ACT_SELECT: begin
        if (it.arg < CONSOLES_DEF) begin
          shown = it.arg;
          fc = it.arg;
          touched = 1'b1;
        end
      end
      ACT_READ: begin
        if (it.arg < MEM_CELLS_DEF) {r.cattr, r.cch} = screen_mem[it.arg];
      end
      ACT_PUT: begin
        cur = cursor_at[c];
        if (it.ch == CH_NEWLINE) begin
          if (cur < base + REGION - COLS) cur = base + COLS * ((cur - base) / COLS + 1);
        end else if (it.ch == CH_BACKSPACE) begin
          if (cur > base) begin
            cur--;
            screen_mem[cur] = {color_of[c], CH_BLANK};
          end
        end else if (cur < base + REGION - 1) begin
          screen_mem[cur] = {color_of[c], it.ch};
          cur++;
        end
        cursor_at[c] = cur;
        follow_view(c);
        touched = 1'b1;
      end
      ACT_COLOR: color_of[c] = it.arg[7:0];
      ACT_SCROLL: begin
        if (it.arg == DIR_UP) begin
          if (view_at[c] > base) view_at[c] -= COLS;
        end else if (it.arg == DIR_DOWN) begin
          if (view_at[c] + SCREEN < base + REGION) view_at[c] += COLS;
        end
        touched = 1'b1;
      end
      ACT_CLEAR: begin
        for (int unsigned i = 0; i < REGION; i++) screen_mem[base + i] = {blank_color, CH_NULL};
        cursor_at[c] = base;
        view_at[c] = base;
        touched = 1'b1;
      end
      default: begin
        x = 32'(it.arg[31:16]);
        y = 32'(it.arg[15:0]);
        if (x > COLS - 1) x = COLS - 1;
        if (y > LAST_ROW) y = LAST_ROW;
        view_at[c] = base;
        cursor_at[c] = base + y * COLS + x;
        touched = 1'b1;
      end
    endcase
    if (touched && fc == shown) begin
      r.upd = 1'b1;
      r.cur = cursor_at[fc][13:0];
      r.start = view_at[fc][13:0];
    end
    return r;
  endfunction

  function automatic cmd_item_t mk(action_t a, int unsigned c, int unsigned ch,
                                   logic [31:0] arg);
    cmd_item_t it;
    it.act = a;
    it.con = c[1:0];
    it.ch = ch[7:0];
    it.arg = arg;
    return it;
  endfunction

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Driver: predicts accepted items, then offers the next pending one
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready)
        console_expect_q.push_back(predict_console({action_t'(cmd.action), cmd.console_index,
                                                    cmd.char_code, cmd.argument}));
      if (!cmd.valid || cmd.ready) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          cmd.action        <= pending_cmds[0].act;
          cmd.console_index <= pending_cmds[0].con;
          cmd.char_code     <= pending_cmds[0].ch;
          cmd.argument      <= pending_cmds[0].arg;
          cmd.valid         <= 1'b1;
          void'(pending_cmds.pop_front());
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison
  always @(posedge clk) begin
    rsp_item_t exp_r;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (console_expect_q.size() == 0) begin
          $display("%0t: unexpected result item", $time);
          errors++;
        end else begin
          exp_r = console_expect_q.pop_front();
          if (rsp.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, rsp.status);
            errors++;
          end
          if (rsp.display_update !== exp_r.upd) begin
            $display("%0t: display_update exp %0d got %0d", $time, exp_r.upd,
                     rsp.display_update);
            errors++;
          end
          if (rsp.cursor_position !== exp_r.cur) begin
            $display("%0t: cursor_position exp %0d got %0d", $time, exp_r.cur,
                     rsp.cursor_position);
            errors++;
          end
          if (rsp.display_start !== exp_r.start) begin
            $display("%0t: display_start exp %0d got %0d", $time, exp_r.start,
                     rsp.display_start);
            errors++;
          end
          if (rsp.cell_char !== exp_r.cch) begin
            $display("%0t: cell_char exp %0h got %0h", $time, exp_r.cch, rsp.cell_char);
            errors++;
          end
          if (rsp.cell_attr !== exp_r.cattr) begin
            $display("%0t: cell_attr exp %0h got %0h", $time, exp_r.cattr, rsp.cell_attr);
            errors++;
          end
        end
      end
      rsp.ready <= calm || $urandom_range(99) >= 30;
    end
  end

  // Block until every item is taken and answered
  task automatic drain();
    while (pending_cmds.size() > 0 || cmd.valid || console_expect_q.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_color(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    blank_color = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random phase: mostly text bursts on random consoles, with other actions mixed in
  task automatic random_phase(int unsigned n);
    int unsigned cnt;
    int unsigned c;
    int unsigned len;
    int unsigned k;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(99);
      c = $urandom_range(3);
      if (k < 40) begin
        if ($urandom_range(1)) begin
          pending_cmds.push_back(mk(ACT_GOTO, c, $urandom,
                                    {16'($urandom_range(90)), 16'($urandom_range(55))}));
          cnt++;
        end
        len = $urandom_range(5, 40);
        for (int unsigned i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0: pending_cmds.push_back(mk(ACT_PUT, c, CH_NEWLINE, $urandom));
            1: pending_cmds.push_back(mk(ACT_PUT, c, CH_BACKSPACE, $urandom));
            default: pending_cmds.push_back(mk(ACT_PUT, c, $urandom, $urandom));
          endcase
        end
        cnt += len;
      end else begin
        case ($urandom_range(19))
          0, 1: pending_cmds.push_back(mk(ACT_COLOR, c, $urandom, $urandom));
          2, 3: pending_cmds.push_back(mk(ACT_SELECT, c, $urandom,
                                          $urandom_range(3) == 0 ? $urandom : $urandom_range(4)));
          4, 5, 6: pending_cmds.push_back(mk(ACT_SCROLL, c, $urandom,
                                             $urandom_range(4) == 0 ? $urandom : $urandom_range(1)));
          7: pending_cmds.push_back(mk(ACT_CLEAR, c, $urandom, $urandom));
          8, 9: pending_cmds.push_back(mk(ACT_GOTO, c, $urandom, $urandom));
          10: pending_cmds.push_back(mk(ACT_INVALID, c, $urandom, $urandom));
          11: pending_cmds.push_back(mk(ACT_READ, c, $urandom, $urandom));
          default: pending_cmds.push_back(mk(ACT_READ, c, $urandom, $urandom_range(16383)));
        endcase
        cnt++;
      end
    end
  endtask

  // Stimulus sequencing
  initial begin
    cmd.valid = 1'b0;
    cmd.action = ACT_PUT;
    cmd.console_index = '0;
    cmd.char_code = '0;
    cmd.argument = '0;
    rsp.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    calm = 1'b0;
    blank_color = COLOR_RST;
    shown = 0;
    for (int i = 0; i < MEM_CELLS_DEF; i++) screen_mem[i] = '0;
    for (int i = 0; i < CONSOLES_DEF; i++) begin
      cursor_at[i] = i * REGION;
      view_at[i] = i * REGION;
      color_of[i] = COLOR_RST;
    end
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: edges of every action
    write_color(8'hff);
    pending_cmds.push_back(mk(ACT_PUT, 0, CH_BACKSPACE, 0));         // backspace at region start
    pending_cmds.push_back(mk(ACT_PUT, 0, 8'h41, 0));
    pending_cmds.push_back(mk(ACT_PUT, 0, CH_BACKSPACE, 0));         // writes a blank
    pending_cmds.push_back(mk(ACT_PUT, 0, CH_NEWLINE, 0));
    pending_cmds.push_back(mk(ACT_COLOR, 0, 0, 32'hffff_ffa5));
    pending_cmds.push_back(mk(ACT_PUT, 0, 8'hff, 0));
    pending_cmds.push_back(mk(ACT_READ, 3, 0, COLS));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 32'hffff_ffff));       // beyond memory
    pending_cmds.push_back(mk(ACT_SCROLL, 0, 0, DIR_UP));            // already at top
    pending_cmds.push_back(mk(ACT_SCROLL, 0, 0, DIR_DOWN));
    pending_cmds.push_back(mk(ACT_SCROLL, 0, 0, 32'd7));             // unknown direction
    pending_cmds.push_back(mk(ACT_GOTO, 0, 0, 32'd30));              // cursor below the screen
    pending_cmds.push_back(mk(ACT_PUT, 0, 8'h00, 0));                // view follows
    pending_cmds.push_back(mk(ACT_GOTO, 1, 0, 32'hffff_ffff));       // saturates to last cell
    pending_cmds.push_back(mk(ACT_SELECT, 0, 0, 32'd1));
    pending_cmds.push_back(mk(ACT_PUT, 1, 8'h7e, 0));                // last cell: no effect
    pending_cmds.push_back(mk(ACT_PUT, 1, CH_NEWLINE, 0));           // newline in last line
    pending_cmds.push_back(mk(ACT_SCROLL, 1, 0, DIR_DOWN));          // view at bottom
    pending_cmds.push_back(mk(ACT_SELECT, 0, 0, 32'd4));             // ignored target
    pending_cmds.push_back(mk(ACT_SELECT, 0, 0, 32'h8000_0000));
    pending_cmds.push_back(mk(ACT_CLEAR, 2, 0, 0));
    pending_cmds.push_back(mk(ACT_READ, 0, 0, 2 * REGION + 5));
    pending_cmds.push_back(mk(ACT_INVALID, 3, 8'hff, 32'hffff_ffff));
    pending_cmds.push_back(mk(ACT_SELECT, 0, 0, 32'd3));
    pending_cmds.push_back(mk(ACT_CLEAR, 3, 0, 0));
    drain();

    write_color(8'h00);
    random_phase(300);
    drain();
    write_color(8'($urandom));
    calm = 1'b1;
    random_phase(200);
    drain();
    calm = 1'b0;
    write_color(8'hff);
    random_phase(400);
    drain();

    if (errors == 0) begin
      $display("tb_text_console_engine passed");
    end else begin
      $display("tb_text_console_engine failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("tb_text_console_engine failed");
    $finish;
  end

endmodule
